[rtl/abkf_pkg.sv]
// Shared types, constants and saturating fixed-point helpers for the
// angle and gyro-bias Kalman filter. No dependencies.
`default_nettype none
package abkf_pkg;

    localparam int WORD_BITS    = 32;
    localparam int FRAC_BITS    = 16;
    localparam int IO_BITS      = 32;
    localparam int CFG_BITS     = 31;
    localparam int DT_BITS      = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int NUM_LANES    = 2;
    localparam int EXT_BITS     = (WORD_BITS > IO_BITS ? WORD_BITS : IO_BITS) + 2;
    localparam int PROD_BITS    = 2 * WORD_BITS;
    localparam int SHIFT_BITS   = PROD_BITS - FRAC_BITS;
    localparam int DVD_BITS     = WORD_BITS + FRAC_BITS;
    localparam int CNT_BITS     = $clog2(WORD_BITS + 1);

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic        [WORD_BITS-1:0] t_mag;
    typedef logic signed [EXT_BITS-1:0]  t_ext;
    typedef logic signed [IO_BITS-1:0]   t_io;

    localparam t_word WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_word COV_RESET = (FRAC_BITS < WORD_BITS - 1) ?
                                  (t_word'(1) <<< FRAC_BITS) : WORD_MAX;
    localparam t_ext  IO_MAX_EXT = t_ext'({1'b0, {(IO_BITS-1){1'b1}}});
    localparam t_ext  IO_MIN_EXT = -IO_MAX_EXT - t_ext'(1);
    localparam logic [SHIFT_BITS-1:0] SHIFT_LIM = SHIFT_BITS'(WORD_MAX);

    localparam logic [CFG_BITS-1:0] ANGLE_NOISE_RESET = CFG_BITS'(131);
    localparam logic [CFG_BITS-1:0] BIAS_NOISE_RESET  = CFG_BITS'(197);
    localparam logic [CFG_BITS-1:0] MEAS_NOISE_RESET  = CFG_BITS'(32768);
    localparam logic [DT_BITS-1:0]  TIME_STEP_RESET   = DT_BITS'(747);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ANGLE_NOISE = 2'd0,
        CFG_BIAS_NOISE  = 2'd1,
        CFG_MEAS_NOISE  = 2'd2,
        CFG_TIME_STEP   = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_ANGLE_PRED = 4'd0,
        OP_AA_PRED    = 4'd1,
        OP_CROSS_PRED = 4'd2,
        OP_BB_PRED    = 4'd3,
        OP_BA_CORR    = 4'd4,
        OP_BB_CORR    = 4'd5,
        OP_AA_CORR    = 4'd6,
        OP_AB_CORR    = 4'd7,
        OP_ANGLE_CORR = 4'd8,
        OP_BIAS_CORR  = 4'd9
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE       = 4'd0,
        S_PRED       = 4'd1,
        S_PRED_DRAIN = 4'd2,
        S_INNOV      = 4'd3,
        S_DIV_GO     = 4'd4,
        S_DIV_WAIT   = 4'd5,
        S_CORR       = 4'd6,
        S_CORR_DRAIN = 4'd7,
        S_FIN        = 4'd8
    } t_seq_state;

    typedef enum logic [1:0] {
        DIV_IDLE = 2'd0,
        DIV_RUN  = 2'd1,
        DIV_DONE = 2'd2
    } t_div_state;

    function automatic t_word sat_word(input t_ext v);
        t_word r;
        if (v > t_ext'(WORD_MAX)) begin
            r = WORD_MAX;
        end else if (v < t_ext'(WORD_MIN)) begin
            r = WORD_MIN;
        end else begin
            r = t_word'(v);
        end
        return r;
    endfunction

    function automatic t_word sat_add(input t_word a, input t_word b);
        return sat_word(t_ext'(a) + t_ext'(b));
    endfunction

    function automatic t_word sat_sub(input t_word a, input t_word b);
        return sat_word(t_ext'(a) - t_ext'(b));
    endfunction

    function automatic t_io sat_io(input t_ext v);
        t_io r;
        if (v > IO_MAX_EXT) begin
            r = t_io'(IO_MAX_EXT);
        end else if (v < IO_MIN_EXT) begin
            r = t_io'(IO_MIN_EXT);
        end else begin
            r = t_io'(v);
        end
        return r;
    endfunction

    function automatic t_mag mag_of(input t_word v);
        return v[WORD_BITS-1] ? t_mag'(-v) : t_mag'(v);
    endfunction

    function automatic t_word mag_to_word(input logic neg, input t_mag m);
        t_word r;
        if (m > t_mag'(WORD_MAX)) begin
            r = neg ? WORD_MIN : WORD_MAX;
        end else begin
            r = neg ? -t_word'(m) : t_word'(m);
        end
        return r;
    endfunction

    function automatic t_word prod_to_word(input logic neg,
                                           input logic [PROD_BITS-1:0] p);
        logic [SHIFT_BITS-1:0] s;
        t_word r;
        s = p[PROD_BITS-1:FRAC_BITS];
        if (s > SHIFT_LIM) begin
            r = neg ? WORD_MIN : WORD_MAX;
        end else begin
            r = mag_to_word(neg, t_mag'(s));
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/abkf_div.sv]
// Two-lane restoring fixed-point divider, one quotient bit per lane per cycle,
// sharing one positive divisor. Depends on abkf_pkg.
`default_nettype none
module abkf_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  abkf_pkg::t_word i_num0,
    input  abkf_pkg::t_word i_num1,
    input  abkf_pkg::t_word i_den,
    output logic            o_done,
    output abkf_pkg::t_word o_quo0,
    output abkf_pkg::t_word o_quo1
);

    abkf_pkg::t_div_state                r_state;
    abkf_pkg::t_div_state                n_state;
    logic [abkf_pkg::CNT_BITS-1:0]       r_cnt;
    logic [abkf_pkg::WORD_BITS-2:0]      r_den;
    logic [abkf_pkg::WORD_BITS-2:0]      r_rem [abkf_pkg::NUM_LANES];
    abkf_pkg::t_mag                      r_dvd [abkf_pkg::NUM_LANES];
    abkf_pkg::t_mag                      r_quo [abkf_pkg::NUM_LANES];
    logic                                r_neg [abkf_pkg::NUM_LANES];
    logic                                r_ovf [abkf_pkg::NUM_LANES];

    abkf_pkg::t_word                     num_in  [abkf_pkg::NUM_LANES];
    abkf_pkg::t_word                     quo_out [abkf_pkg::NUM_LANES];
    logic [abkf_pkg::DVD_BITS-1:0]       start_dvd [abkf_pkg::NUM_LANES];
    logic [abkf_pkg::FRAC_BITS-1:0]      start_hi  [abkf_pkg::NUM_LANES];
    abkf_pkg::t_mag                      trial [abkf_pkg::NUM_LANES];
    abkf_pkg::t_mag                      diff  [abkf_pkg::NUM_LANES];
    logic                                ge    [abkf_pkg::NUM_LANES];
    logic                                load_en;
    logic                                step_en;

    assign num_in[0] = i_num0;
    assign num_in[1] = i_num1;
    assign o_quo0    = quo_out[0];
    assign o_quo1    = quo_out[1];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            abkf_pkg::DIV_IDLE: begin
                if (i_start) n_state = abkf_pkg::DIV_RUN;
            end
            abkf_pkg::DIV_RUN: begin
                if (r_cnt == abkf_pkg::CNT_BITS'(abkf_pkg::WORD_BITS - 1)) begin
                    n_state = abkf_pkg::DIV_DONE;
                end
            end
            abkf_pkg::DIV_DONE: begin
                n_state = abkf_pkg::DIV_IDLE;
            end
            default: begin
                n_state = abkf_pkg::DIV_IDLE;
            end
        endcase
    end

    always_comb begin
        load_en = (r_state == abkf_pkg::DIV_IDLE) && i_start;
        step_en = (r_state == abkf_pkg::DIV_RUN);
        o_done  = (r_state == abkf_pkg::DIV_DONE);
    end

    always_comb begin
        for (int i = 0; i < abkf_pkg::NUM_LANES; i++) begin
            start_dvd[i] = {abkf_pkg::mag_of(num_in[i]), {abkf_pkg::FRAC_BITS{1'b0}}};
            start_hi[i]  = start_dvd[i][abkf_pkg::DVD_BITS-1:abkf_pkg::WORD_BITS];
            trial[i]     = {r_rem[i], r_dvd[i][abkf_pkg::WORD_BITS-1]};
            diff[i]      = trial[i] - abkf_pkg::t_mag'(r_den);
            ge[i]        = trial[i] >= abkf_pkg::t_mag'(r_den);
            quo_out[i]   = r_ovf[i] ?
                           (r_neg[i] ? abkf_pkg::WORD_MIN : abkf_pkg::WORD_MAX) :
                           abkf_pkg::mag_to_word(r_neg[i], r_quo[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= abkf_pkg::DIV_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (load_en) begin
                r_cnt <= '0;
            end else if (step_en) begin
                r_cnt <= r_cnt + abkf_pkg::CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_en) begin
            r_den <= i_den[abkf_pkg::WORD_BITS-2:0];
        end
        for (int i = 0; i < abkf_pkg::NUM_LANES; i++) begin
            if (load_en) begin
                r_rem[i] <= (abkf_pkg::WORD_BITS-1)'(start_hi[i]);
                r_ovf[i] <= abkf_pkg::t_mag'(start_hi[i]) >= abkf_pkg::t_mag'(i_den);
                r_dvd[i] <= start_dvd[i][abkf_pkg::WORD_BITS-1:0];
                r_neg[i] <= num_in[i][abkf_pkg::WORD_BITS-1];
                r_quo[i] <= '0;
            end else if (step_en) begin
                r_rem[i] <= ge[i] ? diff[i][abkf_pkg::WORD_BITS-2:0] :
                                    trial[i][abkf_pkg::WORD_BITS-2:0];
                r_dvd[i] <= {r_dvd[i][abkf_pkg::WORD_BITS-2:0], 1'b0};
                r_quo[i] <= {r_quo[i][abkf_pkg::WORD_BITS-2:0], ge[i]};
            end
        end
    end

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == abkf_pkg::DIV_IDLE))
        else $error("divider started while busy");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == abkf_pkg::DIV_RUN) |-> (r_den != '0))
        else $error("divider running on a zero divisor");

    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == abkf_pkg::DIV_RUN))
        else $error("divider done without a run");

endmodule
`default_nettype wire

[rtl/angle_bias_kalman_filter_top.sv]
// Top level of the angle and gyro-bias Kalman filter: sequencer, shared
// multiplier pipeline, state and configuration registers. Uses abkf_pkg, abkf_div.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one word of angle and rate
//   measurement. Output channel (o_out_valid / i_out_stall) returns the
//   negated filtered angle and the bias-corrected rate, both saturated.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
//   the noise terms and the sample period; write only while idle.
//   Each sample runs prediction, innovation, division and correction before
//   its result reaches the output register; the division is skipped and the
//   gains are zero when the innovation variance is not positive.
//   The divider runs a one-bit-per-cycle loop; ten products run
//   through one shared multiplier, one issued per cycle.
//   o_in_stall is high from acceptance until the result is placed in the
//   output register, so a new word is taken while the previous result waits.
//   If the receiver stalls with a result still held, the filter holds its
//   finished result and stays busy until the output register frees.
//   Synchronous reset restores the register defaults, zero angle and bias,
//   unit diagonal covariance, and empties the output register.
`default_nettype none
module angle_bias_kalman_filter_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  abkf_pkg::t_io                      i_angle_meas,
    input  abkf_pkg::t_io                      i_rate_meas,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output abkf_pkg::t_io                      o_angle_out,
    output abkf_pkg::t_io                      o_rate_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [abkf_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [abkf_pkg::CFG_BITS-1:0]      i_cfg_data
);

    logic [abkf_pkg::CFG_BITS-1:0]   r_angle_noise;
    logic [abkf_pkg::CFG_BITS-1:0]   r_bias_noise;
    logic [abkf_pkg::CFG_BITS-1:0]   r_meas_noise;
    logic [abkf_pkg::DT_BITS-1:0]    r_time_step;

    abkf_pkg::t_seq_state            r_state;
    abkf_pkg::t_seq_state            n_state;
    abkf_pkg::t_op                   r_op;

    abkf_pkg::t_word                 r_angle;
    abkf_pkg::t_word                 r_bias;
    abkf_pkg::t_word                 r_cov_aa;
    abkf_pkg::t_word                 r_cov_ab;
    abkf_pkg::t_word                 r_cov_ba;
    abkf_pkg::t_word                 r_cov_bb;

    abkf_pkg::t_word                 r_meas;
    abkf_pkg::t_word                 r_rate;
    abkf_pkg::t_word                 r_err;
    abkf_pkg::t_word                 r_den;
    logic                            r_den_pos;
    abkf_pkg::t_word                 r_k0;
    abkf_pkg::t_word                 r_k1;

    logic                            r_s1_valid;
    abkf_pkg::t_op                   r_s1_op;
    logic                            r_s1_neg;
    abkf_pkg::t_mag                  r_s1_mag_a;
    abkf_pkg::t_mag                  r_s1_mag_b;
    logic                            r_s2_valid;
    abkf_pkg::t_op                   r_s2_op;
    logic                            r_s2_neg;
    logic [abkf_pkg::PROD_BITS-1:0]  r_s2_prod;

    logic                            r_out_valid;
    abkf_pkg::t_io                   r_angle_out;
    abkf_pkg::t_io                   r_rate_out;

    abkf_pkg::t_word                 dt_w;
    abkf_pkg::t_word                 qa_w;
    abkf_pkg::t_word                 qb_w;
    abkf_pkg::t_word                 rn_w;
    abkf_pkg::t_word                 opa;
    abkf_pkg::t_word                 opb;
    abkf_pkg::t_word                 wb_val;
    abkf_pkg::t_word                 innov_var;

    logic                            in_accept;
    logic                            issue;
    logic                            innov_en;
    logic                            div_start;
    logic                            zero_gain;
    logic                            gain_load;
    logic                            out_load;
    logic                            div_done;
    abkf_pkg::t_word                 div_quo0;
    abkf_pkg::t_word                 div_quo1;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_angle_out = r_angle_out;
    assign o_rate_out  = r_rate_out;

    assign dt_w = abkf_pkg::sat_word(abkf_pkg::t_ext'(r_time_step));
    assign qa_w = abkf_pkg::sat_word(abkf_pkg::t_ext'(r_angle_noise));
    assign qb_w = abkf_pkg::sat_word(abkf_pkg::t_ext'(r_bias_noise));
    assign rn_w = abkf_pkg::sat_word(abkf_pkg::t_ext'(r_meas_noise));

    assign innov_var = abkf_pkg::sat_add(rn_w, r_cov_aa);
    assign wb_val    = abkf_pkg::prod_to_word(r_s2_neg, r_s2_prod);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            abkf_pkg::S_IDLE: begin
                if (i_in_valid) n_state = abkf_pkg::S_PRED;
            end
            abkf_pkg::S_PRED: begin
                if (r_op == abkf_pkg::OP_BB_PRED) n_state = abkf_pkg::S_PRED_DRAIN;
            end
            abkf_pkg::S_PRED_DRAIN: begin
                if (!r_s1_valid && !r_s2_valid) n_state = abkf_pkg::S_INNOV;
            end
            abkf_pkg::S_INNOV: begin
                n_state = abkf_pkg::S_DIV_GO;
            end
            abkf_pkg::S_DIV_GO: begin
                n_state = r_den_pos ? abkf_pkg::S_DIV_WAIT : abkf_pkg::S_CORR;
            end
            abkf_pkg::S_DIV_WAIT: begin
                if (div_done) n_state = abkf_pkg::S_CORR;
            end
            abkf_pkg::S_CORR: begin
                if (r_op == abkf_pkg::OP_BIAS_CORR) n_state = abkf_pkg::S_CORR_DRAIN;
            end
            abkf_pkg::S_CORR_DRAIN: begin
                if (!r_s1_valid && !r_s2_valid) n_state = abkf_pkg::S_FIN;
            end
            abkf_pkg::S_FIN: begin
                if (!r_out_valid || !i_out_stall) n_state = abkf_pkg::S_IDLE;
            end
            default: begin
                n_state = abkf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != abkf_pkg::S_IDLE);
        in_accept  = (r_state == abkf_pkg::S_IDLE) && i_in_valid;
        issue      = (r_state == abkf_pkg::S_PRED) || (r_state == abkf_pkg::S_CORR);
        innov_en   = (r_state == abkf_pkg::S_INNOV);
        div_start  = (r_state == abkf_pkg::S_DIV_GO) && r_den_pos;
        zero_gain  = (r_state == abkf_pkg::S_DIV_GO) && !r_den_pos;
        gain_load  = (r_state == abkf_pkg::S_DIV_WAIT) && div_done;
        out_load   = (r_state == abkf_pkg::S_FIN) && (!r_out_valid || !i_out_stall);
    end

    always_comb begin
        opa = '0;
        opb = dt_w;
        unique case (r_op)
            abkf_pkg::OP_ANGLE_PRED: begin
                opa = abkf_pkg::sat_sub(r_rate, r_bias);
                opb = dt_w;
            end
            abkf_pkg::OP_AA_PRED: begin
                opa = abkf_pkg::sat_sub(abkf_pkg::sat_sub(qa_w, r_cov_ab), r_cov_ba);
                opb = dt_w;
            end
            abkf_pkg::OP_CROSS_PRED: begin
                opa = abkf_pkg::sat_sub('0, r_cov_bb);
                opb = dt_w;
            end
            abkf_pkg::OP_BB_PRED: begin
                opa = qb_w;
                opb = dt_w;
            end
            abkf_pkg::OP_BA_CORR: begin
                opa = r_k1;
                opb = r_cov_aa;
            end
            abkf_pkg::OP_BB_CORR: begin
                opa = r_k1;
                opb = r_cov_ab;
            end
            abkf_pkg::OP_AA_CORR: begin
                opa = r_k0;
                opb = r_cov_aa;
            end
            abkf_pkg::OP_AB_CORR: begin
                opa = r_k0;
                opb = r_cov_ab;
            end
            abkf_pkg::OP_ANGLE_CORR: begin
                opa = r_k0;
                opb = r_err;
            end
            abkf_pkg::OP_BIAS_CORR: begin
                opa = r_k1;
                opb = r_err;
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_noise <= abkf_pkg::ANGLE_NOISE_RESET;
            r_bias_noise  <= abkf_pkg::BIAS_NOISE_RESET;
            r_meas_noise  <= abkf_pkg::MEAS_NOISE_RESET;
            r_time_step   <= abkf_pkg::TIME_STEP_RESET;
        end else if (i_cfg_valid) begin
            unique case (abkf_pkg::t_cfg_idx'(i_cfg_index))
                abkf_pkg::CFG_ANGLE_NOISE: r_angle_noise <= i_cfg_data;
                abkf_pkg::CFG_BIAS_NOISE:  r_bias_noise  <= i_cfg_data;
                abkf_pkg::CFG_MEAS_NOISE:  r_meas_noise  <= i_cfg_data;
                abkf_pkg::CFG_TIME_STEP:   r_time_step   <= i_cfg_data[abkf_pkg::DT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= abkf_pkg::S_IDLE;
            r_op        <= abkf_pkg::OP_ANGLE_PRED;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= issue;
            r_s2_valid <= r_s1_valid;
            if (in_accept) begin
                r_op <= abkf_pkg::OP_ANGLE_PRED;
            end else if (r_state == abkf_pkg::S_DIV_GO) begin
                r_op <= abkf_pkg::OP_BA_CORR;
            end else if (issue) begin
                r_op <= abkf_pkg::t_op'(r_op + 4'd1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle  <= '0;
            r_bias   <= '0;
            r_cov_aa <= abkf_pkg::COV_RESET;
            r_cov_ab <= '0;
            r_cov_ba <= '0;
            r_cov_bb <= abkf_pkg::COV_RESET;
        end else if (r_s2_valid) begin
            unique case (r_s2_op)
                abkf_pkg::OP_ANGLE_PRED: r_angle  <= abkf_pkg::sat_add(r_angle, wb_val);
                abkf_pkg::OP_AA_PRED:    r_cov_aa <= abkf_pkg::sat_add(r_cov_aa, wb_val);
                abkf_pkg::OP_CROSS_PRED: begin
                    r_cov_ab <= abkf_pkg::sat_add(r_cov_ab, wb_val);
                    r_cov_ba <= abkf_pkg::sat_add(r_cov_ba, wb_val);
                end
                abkf_pkg::OP_BB_PRED:    r_cov_bb <= abkf_pkg::sat_add(r_cov_bb, wb_val);
                abkf_pkg::OP_BA_CORR:    r_cov_ba <= abkf_pkg::sat_sub(r_cov_ba, wb_val);
                abkf_pkg::OP_BB_CORR:    r_cov_bb <= abkf_pkg::sat_sub(r_cov_bb, wb_val);
                abkf_pkg::OP_AA_CORR:    r_cov_aa <= abkf_pkg::sat_sub(r_cov_aa, wb_val);
                abkf_pkg::OP_AB_CORR:    r_cov_ab <= abkf_pkg::sat_sub(r_cov_ab, wb_val);
                abkf_pkg::OP_ANGLE_CORR: r_angle  <= abkf_pkg::sat_add(r_angle, wb_val);
                abkf_pkg::OP_BIAS_CORR:  r_bias   <= abkf_pkg::sat_add(r_bias, wb_val);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_meas <= abkf_pkg::sat_word(abkf_pkg::t_ext'(i_angle_meas));
            r_rate <= abkf_pkg::sat_word(abkf_pkg::t_ext'(i_rate_meas));
        end
        if (innov_en) begin
            r_err     <= abkf_pkg::sat_sub(r_meas, r_angle);
            r_den     <= innov_var;
            r_den_pos <= !innov_var[abkf_pkg::WORD_BITS-1] && (innov_var != '0);
        end
        if (zero_gain) begin
            r_k0 <= '0;
            r_k1 <= '0;
        end else if (gain_load) begin
            r_k0 <= div_quo0;
            r_k1 <= div_quo1;
        end
        r_s1_op    <= r_op;
        r_s1_neg   <= opa[abkf_pkg::WORD_BITS-1] ^ opb[abkf_pkg::WORD_BITS-1];
        r_s1_mag_a <= abkf_pkg::mag_of(opa);
        r_s1_mag_b <= abkf_pkg::mag_of(opb);
        r_s2_op    <= r_s1_op;
        r_s2_neg   <= r_s1_neg;
        r_s2_prod  <= abkf_pkg::PROD_BITS'(r_s1_mag_a) * abkf_pkg::PROD_BITS'(r_s1_mag_b);
        if (out_load) begin
            r_angle_out <= abkf_pkg::sat_io(abkf_pkg::t_ext'(0) - abkf_pkg::t_ext'(r_angle));
            r_rate_out  <= abkf_pkg::sat_io(abkf_pkg::t_ext'(abkf_pkg::sat_sub(r_rate, r_bias)));
        end
    end

    abkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num0  (r_cov_aa),
        .i_num1  (r_cov_ba),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo0  (div_quo0),
        .o_quo1  (div_quo1)
    );

    a_accept_starts_pred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == abkf_pkg::S_PRED && r_op == abkf_pkg::OP_ANGLE_PRED))
        else $error("accepted word did not start prediction");

    a_wb_in_mul_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (r_state == abkf_pkg::S_PRED || r_state == abkf_pkg::S_PRED_DRAIN ||
                        r_state == abkf_pkg::S_CORR || r_state == abkf_pkg::S_CORR_DRAIN))
        else $error("product written back outside a multiply phase");

    a_pipe_empty_innov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == abkf_pkg::S_INNOV) |-> (!r_s1_valid && !r_s2_valid))
        else $error("innovation formed before prediction finished");

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for angle_bias_kalman_filter_top: an in-bench fixed-point Kalman
// predictor, bursty angle/rate stimulus and random output stalls. Uses abkf_pkg and the top.
module tb;

    typedef struct packed {
        abkf_pkg::t_io angle;
        abkf_pkg::t_io rate;
    } t_estimate;

    typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_BURSTY} t_flow;
    typedef enum int {TUNE_TYPICAL, TUNE_EDGE, TUNE_WILD} t_tuning;

    localparam logic [abkf_pkg::CFG_BITS-1:0] CFG_FULL = {abkf_pkg::CFG_BITS{1'b1}};
    localparam logic [abkf_pkg::CFG_BITS-1:0] DT_FULL  =
        abkf_pkg::CFG_BITS'({abkf_pkg::DT_BITS{1'b1}});

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    abkf_pkg::t_io                     i_angle_meas = '0;
    abkf_pkg::t_io                     i_rate_meas = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    abkf_pkg::t_io                     o_angle_out;
    abkf_pkg::t_io                     o_rate_out;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [abkf_pkg::CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [abkf_pkg::CFG_BITS-1:0]     i_cfg_data = '0;

    logic [abkf_pkg::CFG_BITS-1:0] q_angle_reg = abkf_pkg::ANGLE_NOISE_RESET;
    logic [abkf_pkg::CFG_BITS-1:0] q_bias_reg  = abkf_pkg::BIAS_NOISE_RESET;
    logic [abkf_pkg::CFG_BITS-1:0] r_meas_reg  = abkf_pkg::MEAS_NOISE_RESET;
    logic [abkf_pkg::DT_BITS-1:0]  dt_reg      = abkf_pkg::TIME_STEP_RESET;

    longint est_angle = 0;
    longint est_bias  = 0;
    longint p_aa = longint'(1) << abkf_pkg::FRAC_BITS;
    longint p_ab = 0;
    longint p_ba = 0;
    longint p_bb = longint'(1) << abkf_pkg::FRAC_BITS;

    t_estimate   pending_estimates[$];
    int unsigned n_errors = 0;
    int unsigned n_flat_innov = 0;
    int unsigned burst_left = 0;

    angle_bias_kalman_filter_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_angle_meas (i_angle_meas),
        .i_rate_meas  (i_rate_meas),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_angle_out  (o_angle_out),
        .o_rate_out   (o_rate_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clamp_word(input longint v);
        if (v > longint'(abkf_pkg::WORD_MAX)) begin
            return longint'(abkf_pkg::WORD_MAX);
        end
        if (v < longint'(abkf_pkg::WORD_MIN)) begin
            return longint'(abkf_pkg::WORD_MIN);
        end
        return v;
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint signed_of_mag(input logic neg, input logic [63:0] m);
        if (m > 64'(abkf_pkg::WORD_MAX)) begin
            return neg ? longint'(abkf_pkg::WORD_MIN) : longint'(abkf_pkg::WORD_MAX);
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // truncate toward zero on the magnitude
    function automatic longint q_mul(input longint a, input longint b);
        logic [63:0] p;
        p = magnitude(a) * magnitude(b);
        return signed_of_mag((a < 0) != (b < 0), p >> abkf_pkg::FRAC_BITS);
    endfunction

    function automatic longint q_div(input longint n, input longint d);
        logic [63:0] q;
        q = (magnitude(n) << abkf_pkg::FRAC_BITS) / 64'(d);
        return signed_of_mag(n < 0, q);
    endfunction

    function automatic t_estimate kalman_update(input abkf_pkg::t_io meas_in,
                                                input abkf_pkg::t_io rate_in);
        longint meas, rate, dt, qa, qb, rn, negbb, err, e, k0, k1, t0, t1;
        t_estimate res;
        meas = meas_in;
        rate = rate_in;
        dt = dt_reg;
        qa = q_angle_reg;
        qb = q_bias_reg;
        rn = r_meas_reg;
        k0 = 0;
        k1 = 0;

        est_angle = clamp_word(est_angle + q_mul(clamp_word(rate - est_bias), dt));
        negbb = clamp_word(-p_bb);
        p_aa = clamp_word(p_aa + q_mul(clamp_word(clamp_word(qa - p_ab) - p_ba), dt));
        p_ab = clamp_word(p_ab + q_mul(negbb, dt));
        p_ba = clamp_word(p_ba + q_mul(negbb, dt));
        p_bb = clamp_word(p_bb + q_mul(qb, dt));

        err = clamp_word(meas - est_angle);
        e = clamp_word(rn + p_aa);
        if (e > 0) begin
            k0 = q_div(p_aa, e);
            k1 = q_div(p_ba, e);
        end else begin
            n_flat_innov++;
        end
        t0 = p_aa;
        t1 = p_ab;
        p_aa = clamp_word(p_aa - q_mul(k0, t0));
        p_ab = clamp_word(p_ab - q_mul(k0, t1));
        p_ba = clamp_word(p_ba - q_mul(k1, t0));
        p_bb = clamp_word(p_bb - q_mul(k1, t1));
        est_angle = clamp_word(est_angle + q_mul(k0, err));
        est_bias = clamp_word(est_bias + q_mul(k1, err));

        res.angle = abkf_pkg::t_io'(clamp_word(-est_angle));
        res.rate = abkf_pkg::t_io'(clamp_word(rate - est_bias));
        return res;
    endfunction

    function automatic abkf_pkg::t_io pick_value(input int unsigned span);
        abkf_pkg::t_io v;
        case ($urandom_range(0, 9))
            0: v = abkf_pkg::t_io'($urandom);
            1: begin
                case ($urandom_range(0, 4))
                    0: v = abkf_pkg::t_io'(abkf_pkg::WORD_MIN);
                    1: v = abkf_pkg::t_io'(abkf_pkg::WORD_MAX);
                    2: v = '0;
                    3: v = '1;
                    default: v = abkf_pkg::t_io'(1);
                endcase
            end
            default: v = abkf_pkg::t_io'(longint'($urandom_range(0, 2 * span)) -
                                         longint'(span));
        endcase
        return v;
    endfunction

    function automatic logic [abkf_pkg::CFG_BITS-1:0] pick_edge();
        case ($urandom_range(0, 2))
            0: return '0;
            1: return abkf_pkg::CFG_BITS'(1);
            default: return CFG_FULL;
        endcase
    endfunction

    task automatic write_reg(input abkf_pkg::t_cfg_idx idx,
                             input logic [abkf_pkg::CFG_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        case (idx)
            abkf_pkg::CFG_ANGLE_NOISE: q_angle_reg = value;
            abkf_pkg::CFG_BIAS_NOISE:  q_bias_reg = value;
            abkf_pkg::CFG_MEAS_NOISE:  r_meas_reg = value;
            abkf_pkg::CFG_TIME_STEP:   dt_reg = value[abkf_pkg::DT_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_tuning(input logic [abkf_pkg::CFG_BITS-1:0] qa,
                              input logic [abkf_pkg::CFG_BITS-1:0] qb,
                              input logic [abkf_pkg::CFG_BITS-1:0] rn,
                              input logic [abkf_pkg::CFG_BITS-1:0] dt);
        write_reg(abkf_pkg::CFG_ANGLE_NOISE, qa);
        write_reg(abkf_pkg::CFG_BIAS_NOISE, qb);
        write_reg(abkf_pkg::CFG_MEAS_NOISE, rn);
        write_reg(abkf_pkg::CFG_TIME_STEP, dt);
    endtask

    task automatic send_sample(input abkf_pkg::t_io angle_w, input abkf_pkg::t_io rate_w);
        int unsigned gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_angle_meas <= angle_w;
        i_rate_meas <= rate_w;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        pending_estimates.push_back(kalman_update(angle_w, rate_w));
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 8);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // hold input idle until every estimate is back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_estimates.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_sample(abkf_pkg::t_io'(5 * 65536), abkf_pkg::t_io'(-2 * 65536));
        send_sample(abkf_pkg::t_io'(-30 * 65536), abkf_pkg::t_io'(100 * 65536));
        send_sample(abkf_pkg::t_io'(12345), abkf_pkg::t_io'(-777));
        wait_drained();
    endtask

    // zero noise with a full time step collapses the angle variance to zero, giving a flat innovation
    task automatic test_zero_noise();
        int unsigned n;
        set_tuning('0, '0, '0, DT_FULL);
        n = 0;
        while (n < 12 && n_flat_innov < 2) begin
            send_sample(pick_value(1 << 22), pick_value(1 << 22));
            n++;
        end
        wait_drained();
    endtask

    task automatic test_field_extremes();
        set_tuning(CFG_FULL, CFG_FULL, CFG_FULL, DT_FULL);
        send_sample(abkf_pkg::t_io'(abkf_pkg::WORD_MIN), abkf_pkg::t_io'(abkf_pkg::WORD_MIN));
        send_sample(abkf_pkg::t_io'(abkf_pkg::WORD_MAX), abkf_pkg::t_io'(abkf_pkg::WORD_MAX));
        send_sample(abkf_pkg::t_io'(abkf_pkg::WORD_MIN), abkf_pkg::t_io'(abkf_pkg::WORD_MAX));
        send_sample(abkf_pkg::t_io'(abkf_pkg::WORD_MAX), abkf_pkg::t_io'(abkf_pkg::WORD_MIN));
        send_sample('0, '0);
        send_sample('1, abkf_pkg::t_io'(1));
        wait_drained();
    endtask

    task automatic test_frozen_step();
        set_tuning(CFG_FULL, '0, abkf_pkg::CFG_BITS'(1), '0);
        send_sample(abkf_pkg::t_io'(abkf_pkg::WORD_MAX), abkf_pkg::t_io'(3 * 65536));
        send_sample(abkf_pkg::t_io'(-65536), abkf_pkg::t_io'(abkf_pkg::WORD_MIN));
        send_sample('0, '1);
        wait_drained();
    endtask

    task automatic test_random_stream();
        int unsigned span;
        for (int phase = 0; phase < 9; phase++) begin
            case (t_tuning'(phase % 3))
                TUNE_TYPICAL: begin
                    set_tuning(abkf_pkg::CFG_BITS'($urandom_range(0, 2000)),
                               abkf_pkg::CFG_BITS'($urandom_range(0, 2000)),
                               abkf_pkg::CFG_BITS'($urandom_range(500, 200000)),
                               abkf_pkg::CFG_BITS'($urandom_range(64, 4000)));
                    span = 6000000;
                end
                TUNE_EDGE: begin
                    set_tuning(pick_edge(), pick_edge(), pick_edge(),
                               ($urandom_range(0, 1) != 0) ? DT_FULL :
                               abkf_pkg::CFG_BITS'($urandom_range(0, 3)));
                    span = 1 << 30;
                end
                default: begin
                    set_tuning(abkf_pkg::CFG_BITS'($urandom), abkf_pkg::CFG_BITS'($urandom),
                               abkf_pkg::CFG_BITS'($urandom), abkf_pkg::CFG_BITS'($urandom));
                    span = $urandom_range(1, 1 << 30);
                end
            endcase
            repeat (125) begin
                send_sample(pick_value(span), pick_value(span));
                if ($urandom_range(0, 149) == 0) begin
                    wait_drained();
                end
            end
            wait_drained();
        end
    endtask

    initial begin : stall_pattern
        t_flow       flow;
        int unsigned span_left;
        flow = FLOW_FREE;
        span_left = 0;
        forever begin
            @(negedge i_clk);
            if (span_left == 0) begin
                flow = t_flow'($urandom_range(0, 3));
                span_left = $urandom_range(20, 300);
            end
            span_left--;
            case (flow)
                FLOW_FREE:   i_out_stall <= 1'b0;
                FLOW_LIGHT:  i_out_stall <= ($urandom_range(0, 3) == 0);
                FLOW_HEAVY:  i_out_stall <= ($urandom_range(0, 3) != 0);
                default:     i_out_stall <= ((span_left % 32) < 12);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_estimates
        t_estimate want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_estimates.size() == 0) begin
                $error("output word with no estimate pending");
                n_errors++;
            end else begin
                want = pending_estimates.pop_front();
                if (o_angle_out !== want.angle) begin
                    $error("angle_out: expected %0d, got %0d", want.angle, o_angle_out);
                    n_errors++;
                end
                if (o_rate_out !== want.rate) begin
                    $error("rate_out: expected %0d, got %0d", want.rate, o_rate_out);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_zero_noise();
        test_field_extremes();
        test_frozen_step();
        test_random_stream();
        wait_drained();
        repeat (80) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
